@@ src/lib_pkg.sv @@
// ----------------------------------------------------------------------------
// lib_pkg
// Shared types and codes of the lazily initialised bitmap.
// ----------------------------------------------------------------------------
package lib_pkg;

  // Width of a bit index on the request channel.
  localparam int INDEX_W = 10;

  // Operation codes carried in the func field of a request.
  localparam logic [1:0] FUNC_TEST  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // One entry of the slot store: the owning index and its erased mark.
  typedef struct packed {
    logic               erased;
    logic [INDEX_W-1:0] owner;
  } owner_t;

endpackage

@@ src/lib_ram.sv @@
// ----------------------------------------------------------------------------
// lib_ram
// Simple dual-port RAM with one write port and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/lazy_init_bitmap.sv @@
// ----------------------------------------------------------------------------
// lazy_init_bitmap
// Bitmap of NUM_BITS bits held in two uncleared memories and a top counter.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel carries an operation (test, set or clear)
//   and a bit index. Every request produces exactly one result on the out_
//   channel, giving the state of that bit before and after the operation.
//   An index at or beyond NUM_BITS changes nothing and returns zeros; the
//   unused operation code behaves as a test.
//   On acceptance the forward table is read, then the slot store at the
//   slot it names, before the write-back; the next request is accepted in
//   the write-back cycle, which waits while the receiver stalls, so a new
//   request overlaps only the write-back of the last one. A forward table
//   write in that cycle is bypassed to the following request.
//   Reset clears only the top counter and the control state; the memories
//   keep any contents and need no clearing pass, as every entry is checked
//   against the top counter and the back reference of its slot.
//   The result sits in an output register. While the receiver stalls, the
//   block holds the pending result and accepts at most one further request,
//   which waits with its slot store data until the result register frees.
// ----------------------------------------------------------------------------
module lazy_init_bitmap #(
  parameter int NUM_BITS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [lib_pkg::INDEX_W-1:0] in_bit_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_bit_before,
  output logic                        out_bit_after
);

  localparam int IDX_W = $clog2(NUM_BITS);
  localparam int CNT_W = $clog2(NUM_BITS + 1);
  localparam int OWN_W = $bits(lib_pkg::owner_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FWD,
    S_OWN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  func_r;
  logic [lib_pkg::INDEX_W-1:0] idx_r;
  logic                        in_range_r;
  logic [IDX_W-1:0]            slot_r;
  logic [CNT_W-1:0]            top_r, top_nxt;
  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            hit_slot_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_before_r, out_after_r;

  logic                        in_fire;
  logic                        out_free;
  logic                        res_fire;
  logic [IDX_W-1:0]            fwd_rd_data;
  logic [IDX_W-1:0]            slot_sel;
  logic [OWN_W-1:0]            own_rd_raw;
  lib_pkg::owner_t             own_rd;
  logic                        live;
  logic                        is_set;
  logic                        is_erased;
  logic                        top_full;
  logic                        bit_before;
  logic                        bit_after;
  logic                        fwd_we;
  logic                        own_we;
  logic [IDX_W-1:0]            own_wa;
  lib_pkg::owner_t             own_wd;

  // Handshake decode.
  assign out_free = !out_valid_r || out_ready;
  assign res_fire = (state_r == S_OWN) && out_free;
  assign in_ready = (state_r == S_IDLE) || res_fire;
  assign in_fire  = in_valid && in_ready;

  // Forward table: read at acceptance, written when a new slot is taken.
  lib_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BITS)
  ) u_fwd_ram (
    .clk     (clk),
    .wr_en   (res_fire && fwd_we),
    .wr_addr (IDX_W'(idx_r)),
    .wr_data (top_r[IDX_W-1:0]),
    .rd_en   (in_fire),
    .rd_addr (IDX_W'(in_bit_index)),
    .rd_data (fwd_rd_data)
  );

  // The slot comes from the bypass when the previous request wrote this index.
  assign slot_sel = hit_r ? hit_slot_r : fwd_rd_data;

  // Slot store: read at the forwarded slot, written back in the result cycle.
  lib_ram #(
    .WIDTH (OWN_W),
    .DEPTH (NUM_BITS)
  ) u_own_ram (
    .clk     (clk),
    .wr_en   (res_fire && own_we),
    .wr_addr (own_wa),
    .wr_data (own_wd),
    .rd_en   (state_r == S_FWD),
    .rd_addr (slot_sel),
    .rd_data (own_rd_raw)
  );

  assign own_rd = lib_pkg::owner_t'(own_rd_raw);

  // Membership checks against the top counter and the back reference.
  assign live      = CNT_W'(slot_r) < top_r;
  assign is_set    = live && !own_rd.erased && (own_rd.owner == idx_r);
  assign is_erased = live && own_rd.erased && (own_rd.owner == idx_r);
  assign top_full  = top_r == CNT_W'(NUM_BITS);

  // Operation decode and write-back for the request in the result cycle.
  always_comb begin
    fwd_we        = 1'b0;
    own_we        = 1'b0;
    own_wa        = slot_r;
    own_wd.erased = 1'b0;
    own_wd.owner  = idx_r;
    top_nxt       = top_r;
    bit_before    = 1'b0;
    bit_after     = 1'b0;
    if (in_range_r) begin
      bit_before = is_set;
      bit_after  = is_set;
      case (func_r)
        lib_pkg::FUNC_SET: begin
          if (!is_set) begin
            if (is_erased) begin
              own_we    = 1'b1;
              bit_after = 1'b1;
            end else if (!top_full) begin
              fwd_we    = 1'b1;
              own_we    = 1'b1;
              own_wa    = top_r[IDX_W-1:0];
              top_nxt   = top_r + CNT_W'(1);
              bit_after = 1'b1;
            end
          end
        end
        lib_pkg::FUNC_CLEAR: begin
          if (is_set) begin
            own_we        = 1'b1;
            own_wd.erased = 1'b1;
            bit_after     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        state_nxt = S_OWN;
      end
      S_OWN: begin
        if (res_fire) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_fire ? S_FWD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bypass of a forward table write to a request accepted in the same cycle.
  assign hit_nxt = res_fire && fwd_we && (in_bit_index == idx_r);

  // State, counter and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (res_fire) begin
        top_r        <= top_nxt;
        out_before_r <= bit_before;
        out_after_r  <= bit_after;
      end
      if (in_fire) begin
        func_r     <= in_func;
        idx_r      <= in_bit_index;
        in_range_r <= 32'(in_bit_index) < NUM_BITS;
        hit_r      <= hit_nxt;
        hit_slot_r <= top_r[IDX_W-1:0];
      end
      if (state_r == S_FWD) begin
        slot_r <= slot_sel;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_before = out_before_r;
  assign out_bit_after  = out_after_r;

  // The top counter never passes the number of slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CNT_W'(NUM_BITS))
    else $error("top counter beyond the slot count");

  // The top counter grows by at most one per request and never shrinks.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) |-> (top_r == $past(top_r)) || (top_r == $past(top_r) + CNT_W'(1)))
    else $error("top counter moved by more than one");

  // A result is only raised from the result cycle of the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) && $rose(out_valid_r) |-> $past(state_r == S_OWN))
    else $error("result raised outside the result cycle");

  // A result never leaves a bit set after a clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_fire && (func_r == lib_pkg::FUNC_CLEAR) |=> !out_after_r)
    else $error("bit still set after a clear");

endmodule

@@ dv/lazy_init_bitmap_test.sv @@
// ----------------------------------------------------------------------------
// lazy_init_bitmap_test
// Self-checking bench for the lazily initialised bitmap.
// ----------------------------------------------------------------------------
// A shadow copy of the forward table, the slot store and the top counter
// predicts the before and after bits of every accepted request. Each result
// is checked against the oldest prediction. A short directed sequence comes
// first. Random segments follow, each aimed at a small hot range of indices
// so that sets, clears and slot reuse meet often. Both channels idle at
// random. The receiver also holds off once for a long stretch, so that the
// block fills up and stalls its input.
// ----------------------------------------------------------------------------
module lazy_init_bitmap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BITS = 1 << lib_pkg::INDEX_W;

  // The spare func code behaves as a test.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int RANDOM_REQUESTS = 2000;
  localparam int SEGMENT_LEN     = 100;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 300;

  // Shadow of the bitmap state and the queue of predicted bit pairs.
  class bitmap_shadow;
    typedef struct packed {
      logic prior;
      logic after;
    } bit_pair_t;

    logic [lib_pkg::INDEX_W-1:0] fwd_slot [BITS];
    lib_pkg::owner_t             slot_store [BITS];
    logic [lib_pkg::INDEX_W:0]   top;
    bit_pair_t                   predicted_bits[$];

    int n_requests;
    int n_results;
    int n_errors;
    int n_reused;
    int n_func [4];

    function new();
      for (int i = 0; i < BITS; i++) begin
        fwd_slot[i]   = '0;
        slot_store[i] = '0;
      end
      top        = '0;
      n_requests = 0;
      n_results  = 0;
      n_errors   = 0;
      n_reused   = 0;
      for (int i = 0; i < 4; i++) n_func[i] = 0;
    endfunction

    // A bit is set when its slot is in use and refers back to it unerased.
    function automatic logic is_set(logic [lib_pkg::INDEX_W-1:0] k);
      logic [lib_pkg::INDEX_W-1:0] s;
      s = fwd_slot[k];
      return ({1'b0, s} < top) && !slot_store[s].erased && slot_store[s].owner == k;
    endfunction

    function automatic logic is_erased(logic [lib_pkg::INDEX_W-1:0] k);
      logic [lib_pkg::INDEX_W-1:0] s;
      s = fwd_slot[k];
      return ({1'b0, s} < top) && slot_store[s].erased && slot_store[s].owner == k;
    endfunction

    // Apply one accepted request and queue the bits that it should return.
    function automatic void note_request(logic [1:0] f, logic [lib_pkg::INDEX_W-1:0] k);
      bit_pair_t p;
      p.prior = is_set(k);
      if (f == lib_pkg::FUNC_SET && !p.prior) begin
        if (is_erased(k)) begin
          slot_store[fwd_slot[k]].erased = 1'b0;
          n_reused++;
        end else if (top < BITS) begin
          fwd_slot[k] = top[lib_pkg::INDEX_W-1:0];
          slot_store[top[lib_pkg::INDEX_W-1:0]] = '{erased: 1'b0, owner: k};
          top++;
        end
      end else if (f == lib_pkg::FUNC_CLEAR && p.prior) begin
        slot_store[fwd_slot[k]].erased = 1'b1;
      end
      p.after = is_set(k);
      predicted_bits.push_back(p);
      n_requests++;
      n_func[f]++;
    endfunction

    // Compare one accepted result with the oldest prediction.
    function automatic void check_result(logic prior, logic after);
      bit_pair_t p;
      n_results++;
      if (predicted_bits.size() == 0) begin
        $display("%0t: result with nothing predicted: before %0b after %0b",
                 $time, prior, after);
        n_errors++;
        return;
      end
      p = predicted_bits.pop_front();
      if (prior !== p.prior) begin
        $display("%0t: bit_before expected %0b actual %0b", $time, p.prior, prior);
        n_errors++;
      end
      if (after !== p.after) begin
        $display("%0t: bit_after expected %0b actual %0b", $time, p.after, after);
        n_errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_func = lib_pkg::FUNC_TEST;
  logic [lib_pkg::INDEX_W-1:0] in_bit_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_bit_before;
  logic                        out_bit_after;

  bitmap_shadow shadow = new();

  // Segments with no idling on either side.
  bit quiet = 1'b0;
  int input_stall_cycles = 0;
  bit long_hold_done = 1'b0;

  lazy_init_bitmap #(
    .NUM_BITS(BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_bit_index  (in_bit_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bit_before(out_bit_before),
    .out_bit_after (out_bit_after)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and wait until the block takes it.
  task automatic send_request(input logic [1:0] f, input logic [lib_pkg::INDEX_W-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_bit_index <= k;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(f, k);
  endtask

  // Random request aimed mostly at a hot range of indices.
  task automatic send_random(input logic [lib_pkg::INDEX_W-1:0] hot_base);
    int r;
    logic [1:0] f;
    logic [lib_pkg::INDEX_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 30)      f = lib_pkg::FUNC_TEST;
    else if (r < 65) f = lib_pkg::FUNC_SET;
    else if (r < 95) f = lib_pkg::FUNC_CLEAR;
    else             f = FUNC_SPARE;
    r = $urandom_range(0, 99);
    if (r < 60)      k = hot_base + lib_pkg::INDEX_W'($urandom_range(0, 15));
    else if (r < 65) k = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else             k = lib_pkg::INDEX_W'($urandom_range(0, BITS - 1));
    send_request(f, k);
  endtask

  // Receiver: checks results, stalls at random and holds off once for long.
  initial begin
    int hold;
    hold = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) shadow.check_result(out_bit_before, out_bit_after);
      if (in_valid && !in_ready) input_stall_cycles++;
      if (!long_hold_done && shadow.n_requests >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
      end else if (hold == 0 && !quiet) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, drain and verdict.
  initial begin
    logic [lib_pkg::INDEX_W-1:0] hot_base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty map, both ends of the range, repeats, slot reuse
    // after an erase, and the spare func code.
    send_request(lib_pkg::FUNC_TEST,  '0);
    send_request(lib_pkg::FUNC_TEST,  '1);
    send_request(lib_pkg::FUNC_SET,   '0);
    send_request(lib_pkg::FUNC_SET,   '1);
    send_request(lib_pkg::FUNC_SET,   '0);
    send_request(lib_pkg::FUNC_TEST,  '0);
    send_request(FUNC_SPARE,          '1);
    send_request(lib_pkg::FUNC_CLEAR, '0);
    send_request(lib_pkg::FUNC_CLEAR, '0);
    send_request(lib_pkg::FUNC_TEST,  '0);
    send_request(lib_pkg::FUNC_SET,   '0);
    send_request(lib_pkg::FUNC_CLEAR, '1);
    send_request(lib_pkg::FUNC_SET,   '1);
    send_request(lib_pkg::FUNC_SET,   10'h155);
    send_request(lib_pkg::FUNC_SET,   10'h2AA);
    send_request(lib_pkg::FUNC_CLEAR, 10'h2AA);
    send_request(FUNC_SPARE,          10'h2AA);
    send_request(lib_pkg::FUNC_TEST,  10'h155);
    send_request(lib_pkg::FUNC_CLEAR, 10'h3FE);
    send_request(lib_pkg::FUNC_SET,   10'h200);
    send_request(lib_pkg::FUNC_TEST,  10'h1FF);

    // Random part in segments, each with its own hot range.
    for (int seg = 0; seg < RANDOM_REQUESTS / SEGMENT_LEN; seg++) begin
      quiet    = ($urandom_range(0, 5) == 0);
      hot_base = lib_pkg::INDEX_W'($urandom_range(0, BITS - 16));
      repeat (SEGMENT_LEN) send_random(hot_base);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain, then leave room for any stray result.
    wait (shadow.predicted_bits.size() == 0);
    repeat (20) @(posedge clk);

    $display("Run: %0d requests (test %0d, set %0d, clear %0d, spare %0d), %0d results.",
             shadow.n_requests, shadow.n_func[lib_pkg::FUNC_TEST],
             shadow.n_func[lib_pkg::FUNC_SET], shadow.n_func[lib_pkg::FUNC_CLEAR],
             shadow.n_func[FUNC_SPARE], shadow.n_results);
    $display("Slots in use at end %0d, erased slots reused %0d, input stalled %0d cycles.",
             shadow.top, shadow.n_reused, input_stall_cycles);
    if (shadow.n_errors == 0 && shadow.predicted_bits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8ms;
    $display("Timeout with %0d results outstanding.", shadow.predicted_bits.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
src/lib_pkg.sv
src/lib_ram.sv
src/lazy_init_bitmap.sv
dv/lazy_init_bitmap_test.sv
